### rtl/assert_macros.svh
// Assertion macros used by the allocator RTL.
// Expects signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/lfsa_pkg.sv
// Shared types and constants for the lowest free slot allocator.
// No dependencies.
package lfsa_pkg;

	localparam int SLOT_W = 6;
	localparam int ITEM_W = 32;
	localparam int OCC_W  = 7;
	localparam int HIN_W  = 32;

	typedef enum logic [1:0] {
		CMD_ADD,
		CMD_LOOKUP,
		CMD_REM_SLOT,
		CMD_REM_HANDLE
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_NOT_FOUND,
		ST_FULL
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_FREE,
		S_SCAN_HANDLE,
		S_READ,
		S_DONE
	} state_t;

	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot;
		logic [ITEM_W-1:0]  item;
		logic [OCC_W-1:0]   occ;
	} res_t;

endpackage

### rtl/lfsa_ram.sv
// Handle store: one write port, one read port with registered read data.
// Uses no package items.
module lfsa_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/lfsa_ctrl.sv
// Sequencer for the allocator: used-slot map, occupancy count, slot scan.
// Depends on lfsa_pkg, lfsa_ram and assert_macros.svh.
`include "assert_macros.svh"

module lfsa_ctrl import lfsa_pkg::*; #(
	parameter int CAPACITY = 64,
	parameter int HW       = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cmd_t              in_cmd,
	input  logic [HIN_W-1:0]  in_handle,
	input  logic [SLOT_W-1:0] in_slot,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res
);

	localparam int IW   = $clog2(CAPACITY);
	localparam int CNTW = $clog2(CAPACITY + 1);

	state_t            state_q, state_d;
	cmd_t              cmd_q;
	logic [HW-1:0]     handle_q;
	logic [IW-1:0]     slot_q;
	logic              slot_ok_q;
	logic [IW:0]       idx_q;
	logic [CAPACITY-1:0] used_q;
	logic [CNTW-1:0]   count_q;
	res_t              res_q;

	logic              rd_vld_s1;
	logic              rd_used_s1;
	logic [IW-1:0]     rd_idx_s1;

	logic              mem_we;
	logic [IW-1:0]     mem_raddr;
	logic [HW-1:0]     mem_rdata;

	logic [IW-1:0]     idx;
	logic              issue;
	logic              match;
	logic              in_range;
	logic [IW-1:0]     in_addr;
	logic [SLOT_W+IW-1:0] in_slot_ext;

	assign idx         = idx_q[IW-1:0];
	assign issue       = idx_q < (IW+1)'(CAPACITY);
	assign match       = rd_vld_s1 && rd_used_s1 && (mem_rdata == handle_q);
	assign in_range    = 32'(in_slot) < CAPACITY;
	assign in_slot_ext = {{IW{1'b0}}, in_slot};
	assign in_addr     = in_slot_ext[IW-1:0];

	function automatic logic [SLOT_W-1:0] slot_fld(input logic [IW-1:0] s);
		logic [SLOT_W+IW-1:0] e;
		e = {{SLOT_W{1'b0}}, s};
		return e[SLOT_W-1:0];
	endfunction

	function automatic logic [ITEM_W-1:0] item_fld(input logic [HW-1:0] h);
		logic [ITEM_W+HW-1:0] e;
		e = {{ITEM_W{1'b0}}, h};
		return e[ITEM_W-1:0];
	endfunction

	function automatic logic [OCC_W-1:0] occ_fld(input logic [CNTW-1:0] c);
		logic [OCC_W+CNTW-1:0] e;
		e = {{OCC_W{1'b0}}, c};
		return e[OCC_W-1:0];
	endfunction

	lfsa_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(HW),
		.AW   (IW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(idx),
		.wdata(handle_q),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_cmd)
						CMD_ADD: begin
							state_d = (count_q == CNTW'(CAPACITY)) ? S_DONE : S_SCAN_FREE;
						end
						CMD_LOOKUP, CMD_REM_SLOT: state_d = S_READ;
						CMD_REM_HANDLE: state_d = S_SCAN_HANDLE;
					endcase
				end
			end
			S_SCAN_FREE: begin
				if (!used_q[idx]) state_d = S_DONE;
			end
			S_SCAN_HANDLE: begin
				if (match || (!issue && !rd_vld_s1)) state_d = S_DONE;
			end
			S_READ: state_d = S_DONE;
			S_DONE: begin
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_raddr = slot_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				mem_raddr = in_addr;
			end
			S_SCAN_FREE: mem_we = !used_q[idx];
			S_SCAN_HANDLE: mem_raddr = idx;
			S_READ: mem_raddr = slot_q;
			S_DONE: res_valid = 1'b1;
			default: mem_raddr = slot_q;
		endcase
	end

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == S_SCAN_HANDLE) && issue && !match;
			case (state_q)
				S_SCAN_FREE: begin
					if (!used_q[idx]) begin
						used_q[idx] <= 1'b1;
						count_q     <= count_q + 1'b1;
					end
				end
				S_SCAN_HANDLE: begin
					if (match) begin
						used_q[rd_idx_s1] <= 1'b0;
						count_q           <= count_q - 1'b1;
					end
				end
				S_READ: begin
					if (cmd_q == CMD_REM_SLOT && slot_ok_q && used_q[slot_q]) begin
						used_q[slot_q] <= 1'b0;
						count_q        <= count_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q     <= in_cmd;
				handle_q  <= in_handle[HW-1:0];
				slot_q    <= in_addr;
				slot_ok_q <= in_range;
				idx_q     <= '0;
				res_q     <= '{status: ST_FULL, slot: '0, item: '0, occ: occ_fld(count_q)};
			end
			S_SCAN_FREE: begin
				if (!used_q[idx]) begin
					res_q <= '{status: ST_OK, slot: slot_fld(idx), item: '0,
					           occ: occ_fld(count_q + 1'b1)};
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_SCAN_HANDLE: begin
				if (issue) idx_q <= idx_q + 1'b1;
				rd_idx_s1  <= idx;
				rd_used_s1 <= used_q[idx];
				if (match) begin
					res_q <= '{status: ST_OK, slot: slot_fld(rd_idx_s1),
					           item: item_fld(mem_rdata), occ: occ_fld(count_q - 1'b1)};
				end else begin
					res_q <= '{status: ST_NOT_FOUND, slot: '0, item: '0, occ: occ_fld(count_q)};
				end
			end
			S_READ: begin
				if (slot_ok_q && used_q[slot_q]) begin
					res_q <= '{status: ST_OK, slot: slot_fld(slot_q), item: item_fld(mem_rdata),
					           occ: (cmd_q == CMD_REM_SLOT) ? occ_fld(count_q - 1'b1)
					                                        : occ_fld(count_q)};
				end else begin
					res_q <= '{status: ST_NOT_FOUND, slot: '0, item: '0, occ: occ_fld(count_q)};
				end
			end
			default: ;
		endcase
	end

	`ASSERT_RST(a_count_matches_map, $countones(used_q) == count_q, "occupancy count off from slot map")
	`ASSERT_RST(a_count_bound, count_q <= CNTW'(CAPACITY), "occupancy count above capacity")
	`ASSERT_RST(a_fail_zero, (res_valid && res.status != ST_OK) |-> (res.slot == '0 && res.item == '0), "failed result carries slot or handle")

endmodule

### rtl/lowest_free_slot_allocator.sv
// Lowest free slot allocator: a handle table indexed by slot, with add, lookup,
// remove by slot and remove by handle. One request at a time, one result each.
// A request is taken while the sequencer is idle, then it works on it alone.
// Add scans the slot map from slot 0 up to the lowest free slot, or goes
// straight to its result when the table is full; lookup and remove by slot
// read the addressed slot; remove by handle scans from slot 0 up, reading one
// stored handle per cycle through the single read port of the handle memory.
// Results sit in an output register, so the next request is taken while a
// result waits. The slot map is cleared by reset, no clearing pass is needed.
// Depends on lfsa_pkg and lfsa_ctrl.
module lowest_free_slot_allocator import lfsa_pkg::*; #(
	parameter int CAPACITY    = 64,
	parameter int HANDLE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // item_handle[31:0], slot_index[37:32], zero pad
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // slot_out[5:0], item_out[37:6], occupancy[44:38], zero pad
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int HW = (HANDLE_BITS < HIN_W) ? HANDLE_BITS : HIN_W;

	logic res_valid;
	logic res_ready;
	res_t res;
	res_t out_q;
	logic out_vld_q;

	lfsa_ctrl #(
		.CAPACITY(CAPACITY),
		.HW      (HW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (cmd_t'(s_tuser)),
		.in_handle(s_tdata[31:0]),
		.in_slot  (s_tdata[37:32]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	assign res_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {3'b000, out_q.occ, out_q.item, out_q.slot};

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for lowest_free_slot_allocator: directed, table-full, backpressure and
// random request streams, each result checked against a behavioral slot table.
// Depends on lfsa_pkg and the allocator RTL.
module tb_top import lfsa_pkg::*; ();

	localparam int NSLOTS = 64;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;   // item_handle[31:0], slot_index[37:32], zero pad
	logic [1:0]  s_tuser  = '0;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;         // slot_out[5:0], item_out[37:6], occupancy[44:38], zero pad
	logic [1:0]  m_tuser;         // status[1:0]

	lowest_free_slot_allocator #(
		.CAPACITY    (NSLOTS),
		.HANDLE_BITS (32)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	// shadow of the slot table
	bit          slot_busy[NSLOTS];
	bit          slot_seen[NSLOTS];   // written at least once
	logic [31:0] slot_val[NSLOTS];
	int unsigned busy_cnt = 0;

	res_t pending_results[$];
	int   mismatch_cnt = 0;
	bit   calm = 1'b0;                // no idling on either side
	int   rx_hold = 0;                // cycles the receiver still holds off

	function automatic res_t apply_request(cmd_t c, logic [31:0] h, logic [5:0] s);
		res_t r;
		bit   done;
		int   i;
		r.status = ST_NOT_FOUND;
		r.slot   = '0;
		r.item   = '0;
		done     = 1'b0;
		case (c)
			CMD_ADD: begin
				r.status = ST_FULL;
				for (i = 0; i < NSLOTS && !done; i++) begin
					if (!slot_busy[i]) begin
						slot_busy[i] = 1'b1;
						slot_seen[i] = 1'b1;
						slot_val[i]  = h;
						busy_cnt++;
						r.status = ST_OK;
						r.slot   = i[5:0];
						done     = 1'b1;
					end
				end
			end
			CMD_LOOKUP: begin
				if (slot_busy[s]) begin
					r.status = ST_OK;
					r.slot   = s;
					r.item   = slot_val[s];
				end
			end
			CMD_REM_SLOT: begin
				if (slot_busy[s]) begin
					slot_busy[s] = 1'b0;
					busy_cnt--;
					r.status = ST_OK;
					r.slot   = s;
					r.item   = slot_val[s];
				end
			end
			default: begin
				// first match from slot 0 up
				for (i = 0; i < NSLOTS && !done; i++) begin
					if (slot_busy[i] && slot_val[i] == h) begin
						slot_busy[i] = 1'b0;
						busy_cnt--;
						r.status = ST_OK;
						r.slot   = i[5:0];
						r.item   = slot_val[i];
						done     = 1'b1;
					end
				end
			end
		endcase
		r.occ = busy_cnt[6:0];
		return r;
	endfunction

	// random slot that is busy, or only ever written; -1 if none
	function automatic int pick_slot(bit busy_only);
		int cand[$];
		int i;
		for (i = 0; i < NSLOTS; i++)
			if (busy_only ? slot_busy[i] : slot_seen[i])
				cand.push_back(i);
		if (cand.size() == 0)
			return -1;
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	task automatic send_req(cmd_t c, logic [31:0] h, logic [5:0] s);
		while (!calm && $urandom_range(0, 99) < 34) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, s, h};
		s_tuser  <= c;
		do @(posedge clk); while (s_tready !== 1'b1);
		pending_results.push_back(apply_request(c, h, s));
	endtask

	task automatic send_random(int add_pct);
		cmd_t        c;
		int          pick;
		int          s;
		logic [31:0] h;
		logic [5:0]  sfield;
		c = CMD_ADD;
		h = $urandom;
		if ($urandom_range(0, 99) >= add_pct) begin
			pick = $urandom_range(0, 2);
			c = (pick == 0) ? CMD_LOOKUP : (pick == 1) ? CMD_REM_SLOT : CMD_REM_HANDLE;
		end
		s = pick_slot($urandom_range(0, 3) != 0);
		if (s < 0)
			s = pick_slot(1'b0);
		if (c == CMD_REM_HANDLE && s >= 0 && $urandom_range(0, 9) < 7)
			h = slot_val[s];
		else if (c == CMD_ADD && s >= 0 && $urandom_range(0, 1) == 1)
			h = slot_val[s];   // duplicate handle
		// never touch a slot that was never written
		if (s < 0 && (c == CMD_LOOKUP || c == CMD_REM_SLOT))
			c = CMD_ADD;
		if (c == CMD_LOOKUP || c == CMD_REM_SLOT)
			sfield = s[5:0];
		else
			sfield = 6'($urandom_range(0, 63));
		send_req(c, h, sfield);
	endtask

	task automatic test_directed();
		send_req(CMD_REM_HANDLE, 32'h0000_0000, 6'h3F);   // empty table
		send_req(CMD_ADD, 32'h0000_0000, 6'h00);
		send_req(CMD_ADD, 32'hFFFF_FFFF, 6'h3F);
		send_req(CMD_ADD, 32'hA5A5_A5A5, 6'h15);
		send_req(CMD_ADD, 32'h5A5A_5A5A, 6'h2A);
		send_req(CMD_ADD, 32'hFFFF_FFFF, 6'h00);          // duplicate at slot 4
		send_req(CMD_LOOKUP, 32'h0000_0000, 6'd0);
		send_req(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd1);
		send_req(CMD_LOOKUP, 32'h0000_0000, 6'd4);
		send_req(CMD_REM_HANDLE, 32'hFFFF_FFFF, 6'h00);   // lowest match first
		send_req(CMD_REM_HANDLE, 32'hFFFF_FFFF, 6'h3F);
		send_req(CMD_REM_HANDLE, 32'hFFFF_FFFF, 6'h00);   // gone
		send_req(CMD_LOOKUP, 32'h0000_0000, 6'd1);        // freed slot
		send_req(CMD_REM_SLOT, 32'h0000_0000, 6'd4);      // freed slot
		send_req(CMD_REM_SLOT, 32'hFFFF_FFFF, 6'd2);
		send_req(CMD_REM_SLOT, 32'h0000_0000, 6'd0);
		send_req(CMD_ADD, 32'h1234_5678, 6'h3F);          // refills slot 0
		send_req(CMD_ADD, 32'h8000_0001, 6'h00);
		send_req(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd3);
		send_req(CMD_REM_HANDLE, 32'h5A5A_5A5A, 6'h15);
		send_req(CMD_LOOKUP, 32'h0000_0000, 6'd3);
		send_req(CMD_ADD, 32'h7FFF_FFFE, 6'h2A);
	endtask

	task automatic test_table_full();
		while (busy_cnt < NSLOTS)
			send_req(CMD_ADD, $urandom, 6'($urandom_range(0, 63)));
		send_req(CMD_ADD, 32'hCAFE_F00D, 6'h3F);
		send_req(CMD_ADD, 32'h0000_0000, 6'h00);
		send_req(CMD_LOOKUP, 32'h0000_0000, 6'd63);
		send_req(CMD_REM_HANDLE, slot_val[63], 6'h00);    // long scan
		send_req(CMD_REM_SLOT, 32'h0000_0000, 6'd63);
		send_req(CMD_REM_SLOT, 32'h0000_0000, 6'd31);
		send_req(CMD_ADD, 32'hDEAD_BEEF, 6'h00);
		send_req(CMD_REM_HANDLE, $urandom, 6'h3F);
		send_req(CMD_ADD, 32'h0F0F_0F0F, 6'h00);
	endtask

	// receiver held off while the sender keeps offering words
	task automatic test_backpressure();
		calm    = 1'b1;
		rx_hold = 300;
		repeat (12) send_random(50);
		calm = 1'b0;
	endtask

	task automatic test_random();
		int add_pct[6] = '{80, 30, 60, 90, 15, 50};
		int ph;
		for (ph = 0; ph < 6; ph++) begin
			calm = (ph == 2);
			repeat (80) send_random(add_pct[ph]);
		end
		calm = 1'b0;
	endtask

	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold = rx_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(0, 99) >= 34);
		end
	end

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (pending_results.size() == 0) begin
				if (mismatch_cnt < 10)
					$display("unexpected result word: st=%0d data=%h", m_tuser, m_tdata);
				mismatch_cnt++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status || m_tdata[5:0] !== want.slot ||
				    m_tdata[37:6] !== want.item || m_tdata[44:38] !== want.occ) begin
					if (mismatch_cnt < 10)
						$display("mismatch: want st=%0d slot=%0d item=%h occ=%0d, got st=%0d slot=%0d item=%h occ=%0d",
							want.status, want.slot, want.item, want.occ,
							m_tuser, m_tdata[5:0], m_tdata[37:6], m_tdata[44:38]);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_backpressure();
		test_random();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
